// ===== rtl/dsu_pkg.sv =====
package dsu_pkg;

    localparam int MAX_PENDING = 16;
    localparam int CNT_W       = $clog2(MAX_PENDING + 1);
    localparam int IDX_W       = $clog2(MAX_PENDING);
    localparam int TRACK_W     = 16;
    localparam int MOVE_W      = 18;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TRACK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP    = 1'd1;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               last_request;
    } t_in_word;

    typedef struct packed {
        logic [TRACK_W-1:0] served_track;
        logic [MOVE_W-1:0]  total_movement;
        logic               overflow;
        logic               last_served;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/dsu_ram.sv =====
module dsu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/disk_sweep_scheduler_unit.sv =====
// Elevator (LOOK) disk scheduler. Requests are loaded one word per cycle
// into a 16-entry store; the word marked last closes the batch (words past
// capacity are dropped and flag overflow on every result of that batch).
// Service order is found by repeated scans through the store's single read
// port: each scan visits all n stored requests and picks the nearest unserved
// one in the current direction, and the reversal costs one extra scan. No new
// request is taken until the last result has been placed in the output
// register.
module disk_sweep_scheduler_unit
    import dsu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state               r_state, n_state;
    logic [TRACK_W-1:0]   r_start, n_start;
    logic                 r_sweep_up, n_sweep_up;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic [TRACK_W-1:0]   r_head, n_head;
    logic [MOVE_W-1:0]    r_sum, n_sum;
    logic                 r_phase2, n_phase2;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic                 r_best_found, n_best_found;
    logic [TRACK_W-1:0]   r_best_val, n_best_val;
    logic [IDX_W-1:0]     r_best_idx, n_best_idx;
    logic [MAX_PENDING-1:0] r_served, n_served;
    logic [CNT_W-1:0]     r_emitted, n_emitted;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out_word, n_out_word;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_raddr;
    logic [TRACK_W-1:0]   ram_rdata;

    logic                 in_acc;
    logic                 want_min;
    logic                 eligible;
    logic                 better;
    logic                 scan_done;
    logic                 out_free;
    logic [TRACK_W-1:0]   head_delta;
    logic                 is_last;

    dsu_ram #(
        .WIDTH (TRACK_W),
        .DEPTH (MAX_PENDING)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_word.track),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign ram_we      = in_acc && (r_count < CNT_W'(MAX_PENDING));
    assign ram_waddr   = r_count[IDX_W-1:0];
    assign ram_raddr   = r_idx[IDX_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // first sweep: up takes the smallest at/above start, down the largest at/below
    assign want_min  = r_sweep_up ^ r_phase2;
    assign eligible  = !r_served[r_cmp_idx] &&
                       (r_phase2 || (r_sweep_up ? (ram_rdata >= r_start)
                                                : (ram_rdata <= r_start)));
    assign better    = !r_best_found ||
                       (want_min ? (ram_rdata < r_best_val) : (ram_rdata > r_best_val));
    assign scan_done = (r_idx == r_count) && !r_cmp_vld;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign head_delta = (r_best_val >= r_head) ? (r_best_val - r_head)
                                               : (r_head - r_best_val);
    assign is_last   = ((r_emitted + CNT_W'(1)) == r_count);

    always_comb begin
        n_state      = r_state;
        n_start      = r_start;
        n_sweep_up   = r_sweep_up;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_head       = r_head;
        n_sum        = r_sum;
        n_phase2     = r_phase2;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_best_found = r_best_found;
        n_best_val   = r_best_val;
        n_best_idx   = r_best_idx;
        n_served     = r_served;
        n_emitted    = r_emitted;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_TRACK: n_start    = i_cfg_data[TRACK_W-1:0];
                CFG_SWEEP_UP:    n_sweep_up = i_cfg_data[0];
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (ram_we) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_word.last_request) begin
                        n_state      = ST_SCAN;
                        n_head       = r_start;
                        n_sum        = '0;
                        n_phase2     = 1'b0;
                        n_idx        = '0;
                        n_cmp_vld    = 1'b0;
                        n_best_found = 1'b0;
                        n_served     = '0;
                        n_emitted    = '0;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, compare the word read back in the next cycle
                if (r_idx < r_count) begin
                    n_idx     = r_idx + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld && eligible && better) begin
                    n_best_found = 1'b1;
                    n_best_val   = ram_rdata;
                    n_best_idx   = r_cmp_idx;
                end
                if (scan_done) begin
                    if (r_best_found) begin
                        n_state = ST_EMIT;
                    end else begin
                        // nothing left ahead of the head: reverse
                        n_phase2 = 1'b1;
                        n_idx    = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_word.served_track    = r_best_val;
                    n_out_word.total_movement  = r_sum + MOVE_W'(head_delta);
                    n_out_word.overflow        = r_ovf;
                    n_out_word.last_served     = is_last;
                    n_sum                      = r_sum + MOVE_W'(head_delta);
                    n_head                     = r_best_val;
                    n_served[r_best_idx]       = 1'b1;
                    n_emitted                  = r_emitted + CNT_W'(1);
                    n_best_found               = 1'b0;
                    n_idx                      = '0;
                    n_cmp_vld                  = 1'b0;
                    if (is_last) begin
                        n_state = ST_IDLE;
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_start      <= '0;
            r_sweep_up   <= 1'b1;
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_head       <= '0;
            r_sum        <= '0;
            r_phase2     <= 1'b0;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_best_found <= 1'b0;
            r_served     <= '0;
            r_emitted    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_start      <= n_start;
            r_sweep_up   <= n_sweep_up;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_head       <= n_head;
            r_sum        <= n_sum;
            r_phase2     <= n_phase2;
            r_idx        <= n_idx;
            r_cmp_vld    <= n_cmp_vld;
            r_best_found <= n_best_found;
            r_served     <= n_served;
            r_emitted    <= n_emitted;
            r_out_valid  <= n_out_valid;
        end
        r_cmp_idx  <= n_cmp_idx;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_out_word <= n_out_word;
    end

endmodule

// ===== sim/tb_disk_sweep_scheduler_unit.sv =====
`timescale 1ns / 1ps

import dsu_pkg::*;

class sweep_scoreboard;
    t_out_word          due_q[$];
    int                 mismatches;
    logic [TRACK_W-1:0] req_store [MAX_PENDING];
    int                 req_count;
    bit                 ovf_seen;
    logic [TRACK_W-1:0] head_pos;
    logic [MOVE_W-1:0]  move_sum;
    logic [TRACK_W-1:0] start_trk;
    bit                 up_first;

    function new();
        mismatches = 0;
        req_count  = 0;
        ovf_seen   = 1'b0;
        head_pos   = '0;
        move_sum   = '0;
        start_trk  = '0;
        up_first   = 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_START_TRACK: start_trk = data[TRACK_W-1:0];
            CFG_SWEEP_UP:    up_first  = data[0];
            default: ;
        endcase
    endfunction

    function void serve(logic [TRACK_W-1:0] trk, bit is_end);
        t_out_word          w;
        logic [TRACK_W-1:0] delta;
        delta = (trk >= head_pos) ? trk - head_pos : head_pos - trk;
        move_sum = move_sum + MOVE_W'(delta);
        head_pos = trk;
        w.served_track   = trk;
        w.total_movement = move_sum;
        w.overflow       = ovf_seen;
        w.last_served    = is_end;
        due_q.push_back(w);
    endfunction

    // store or drop the request; the last one of a batch yields the whole service order
    function void take_request(t_in_word w);
        logic [TRACK_W-1:0] order [MAX_PENDING];
        logic [TRACK_W-1:0] v;
        int                 n;
        int                 i;
        int                 j;
        int                 split;
        int                 k;
        if (req_count < MAX_PENDING) begin
            req_store[req_count] = w.track;
            req_count++;
        end else begin
            ovf_seen = 1'b1;
        end
        if (!w.last_request)
            return;

        n = req_count;
        for (i = 0; i < n; i++) begin
            v = req_store[i];
            j = i;
            while (j > 0 && order[j-1] > v) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end

        head_pos = start_trk;
        move_sum = '0;
        k = 0;
        split = 0;
        if (up_first) begin
            while (split < n && order[split] < start_trk)
                split++;
            for (i = split; i < n; i++) begin
                serve(order[i], k == n - 1);
                k++;
            end
            for (i = split; i > 0; i--) begin
                serve(order[i-1], k == n - 1);
                k++;
            end
        end else begin
            // downward sweep takes the requests at the head itself too
            while (split < n && order[split] <= start_trk)
                split++;
            for (i = split; i > 0; i--) begin
                serve(order[i-1], k == n - 1);
                k++;
            end
            for (i = split; i < n; i++) begin
                serve(order[i], k == n - 1);
                k++;
            end
        end
        req_count = 0;
        ovf_seen  = 1'b0;
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task check_service(t_out_word got);
        t_out_word want;
        if (due_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word: track %0d movement %0d",
                                      got.served_track, got.total_movement));
            return;
        end
        want = due_q.pop_front();
        if (got.served_track !== want.served_track)
            report_mismatch($sformatf("served_track %0d, want %0d",
                                      got.served_track, want.served_track));
        if (got.total_movement !== want.total_movement)
            report_mismatch($sformatf("total_movement %0d, want %0d (track %0d)",
                                      got.total_movement, want.total_movement,
                                      want.served_track));
        if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %0b, want %0b (track %0d)",
                                      got.overflow, want.overflow, want.served_track));
        if (got.last_served !== want.last_served)
            report_mismatch($sformatf("last_served %0b, want %0b (track %0d)",
                                      got.last_served, want.last_served,
                                      want.served_track));
    endtask
endclass

module tb_disk_sweep_scheduler_unit;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 230;
    localparam int DIRECTED_ITEMS = 25;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sweep_scoreboard    sb;
    logic [TRACK_W-1:0] batch_q[$];
    int                 cycle_count = 0;
    int                 items_sent  = 0;
    int                 burst_left  = 0;
    int                 mode_left   = 0;
    t_stall_mode        stall_mode  = STALL_NONE;

    disk_sweep_scheduler_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    // receiver stall pattern: modes of random length, from never to mostly stalled
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 150);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  i_out_stall <= ($urandom_range(0, 1) == 0);
            default:     i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_service(o_out_word);
    end

    // entered and left at a falling edge
    task automatic send_request(input logic [TRACK_W-1:0] trk, input bit is_last);
        t_in_word w;
        w.track        = trk;
        w.last_request = is_last;
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_word  = w;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_request(w);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_batch();
        int i;
        for (i = 0; i < batch_q.size(); i++)
            send_request(batch_q[i], i == batch_q.size() - 1);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.due_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic set_sweep(input logic [TRACK_W-1:0] start, input bit up);
        write_reg(CFG_START_TRACK, start);
        write_reg(CFG_SWEEP_UP, CFG_DATA_W'(up));
    endtask

    task automatic random_batch();
        int                 n;
        int                 pick;
        logic [TRACK_W-1:0] t;
        batch_q.delete();
        pick = $urandom_range(0, 9);
        if (pick < 5)
            n = $urandom_range(1, 6);
        else if (pick < 8)
            n = $urandom_range(7, MAX_PENDING);
        else
            n = $urandom_range(MAX_PENDING + 1, MAX_PENDING + 5);
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                t = TRACK_W'($urandom);
            else if (pick < 6)
                t = sb.start_trk + TRACK_W'($urandom_range(0, 64)) - 16'd32;
            else if (pick < 7 && batch_q.size() > 0)
                t = batch_q[$urandom_range(0, batch_q.size() - 1)];
            else if (pick < 8)
                t = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            else
                t = sb.start_trk;
            batch_q.push_back(t);
        end
        send_batch();
    endtask

    initial begin
        int phase;
        sb = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_START_TRACK;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // upward first: request at the head, a duplicate, both disk edges
        set_sweep(16'd100, 1'b1);
        batch_q = '{16'd100, 16'd100, 16'd50, 16'hFFFF, 16'd0};
        send_batch();
        wait_drained();

        // downward first, request at the head served before the reversal
        set_sweep(16'd100, 1'b0);
        batch_q = '{16'd100, 16'd200, 16'd50};
        send_batch();
        wait_drained();

        // one word past capacity, the dropped one carries the last flag
        set_sweep(16'd30000, 1'b0);
        batch_q.delete();
        repeat (MAX_PENDING + 1) batch_q.push_back(TRACK_W'($urandom));
        send_batch();
        wait_drained();

        phase = 0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            case (phase % 6)
                0: set_sweep(16'h0000, 1'b1);
                1: set_sweep(16'hFFFF, 1'b0);
                2: set_sweep(16'h0000, 1'b0);
                3: set_sweep(16'hFFFF, 1'b1);
                default: set_sweep(TRACK_W'($urandom), 1'($urandom_range(0, 1)));
            endcase
            repeat ($urandom_range(3, 5)) random_batch();
            wait_drained();
            phase++;
        end

        wait_drained();
        if (sb.due_q.size() == 0 && sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
